/* rtl/stroke_point_predictor_top_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef STROKE_POINT_PREDICTOR_TOP_DEFINES_SVH
`define STROKE_POINT_PREDICTOR_TOP_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define SPP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SPP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/spp_pkg.sv */
`default_nettype none
package spp_pkg;

   localparam int HISTORY_DEPTH = 4;
   localparam int MAX_PREDICTED = 3;

   localparam int POS_W  = 24;
   localparam int TIME_W = 48;
   localparam int DUR_W  = 20;
   localparam int SIZE_W = 15;
   localparam int INT_W  = 17;
   localparam int GAP_W  = 20;
   localparam int LIFE_W = 27;
   localparam int CSR_W  = 27;
   localparam int IDX_W  = 3;

   // Divider: |v| * 65536 over the screen size.
   localparam int DVD_W = 41;
   localparam int DCNT_W = 6;

   localparam logic [DUR_W-1:0]  DUR_RST  = DUR_W'(0);
   localparam logic [SIZE_W-1:0] WID_RST  = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0] HGT_RST  = SIZE_W'(1080);
   localparam logic [INT_W-1:0]  INT_RST  = INT_W'(5000);
   localparam logic [GAP_W-1:0]  GAP_RST  = GAP_W'(10000);
   localparam logic [LIFE_W-1:0] LIFE_RST = LIFE_W'(0);

   // Squared normalized speed at or above this gives the full horizon.
   localparam logic [49:0] SPEED_THRESH = 50'd2814749768;
   localparam logic [31:0] SPEED_SCALE  = 32'd100000;
   localparam logic [24:0] NORM_MAX     = 25'h1000000;

   typedef enum logic [IDX_W-1:0] {
      CSR_DURATION = 3'd0,
      CSR_WIDTH    = 3'd1,
      CSR_HEIGHT   = 3'd2,
      CSR_INTERVAL = 3'd3,
      CSR_MAX_GAP  = 3'd4,
      CSR_LIFE     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_PREDICT = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_ADVANCE = 2'd3
   } command_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [POS_W-1:0] sat24(input logic signed [35:0] v);
      logic [POS_W-1:0] r;
      if (v > 36'sd8388607) begin
         r = 24'h7FFFFF;
      end else if (v < -36'sd8388608) begin
         r = 24'h800000;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/spp_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module spp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire spp_pkg::div_ctl_type          ctl,
   input  wire logic [spp_pkg::DVD_W-1:0]     dividend,
   input  wire logic [spp_pkg::SIZE_W-1:0]    divisor,
   output spp_pkg::div_stat_type              stat,
   output logic [spp_pkg::DVD_W-1:0]          quotient
);

   logic [spp_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [spp_pkg::SIZE_W-1:0] rem_ff, rem_in;
   logic [spp_pkg::SIZE_W-1:0] dvs_ff, dvs_in;
   logic [spp_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [spp_pkg::SIZE_W:0]   rem_sh;
   logic                       ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[spp_pkg::DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? spp_pkg::SIZE_W'(1) : divisor;
         cnt_in  = spp_pkg::DCNT_W'(spp_pkg::DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? spp_pkg::SIZE_W'(rem_sh - {1'b0, dvs_ff})
                     : rem_sh[spp_pkg::SIZE_W-1:0];
         dvd_in = {dvd_ff[spp_pkg::DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == spp_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dvd_ff;

endmodule
`default_nettype wire

/* rtl/stroke_point_predictor_top.sv */
// Add point, clear history and advance time without a life complete in the idle state; advance
// time with a life passes through the expire state, dropping expired points one at a time. A
// predict runs a prep state, two divisions on the shared divider, the speed and horizon products
// on the shared 32x32 multiplier, a compare state and the STEP and LAST build states before its
// first beat, and each further beat once the previous one is taken. One item is in flight at a time.
// Synchronous active-high reset empties the history, loads the register defaults, drops any beat.
`default_nettype none
module stroke_point_predictor_top #(
   parameter int HISTORY_DEPTH = spp_pkg::HISTORY_DEPTH,
   parameter int MAX_PREDICTED = spp_pkg::MAX_PREDICTED
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_command,
   input  wire logic signed [spp_pkg::POS_W-1:0] req_x_pos,
   input  wire logic signed [spp_pkg::POS_W-1:0] req_y_pos,
   input  wire logic [spp_pkg::TIME_W-1:0]    req_time_us,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [spp_pkg::POS_W-1:0]   rsp_pred_x,
   output logic signed [spp_pkg::POS_W-1:0]   rsp_pred_y,
   output logic [spp_pkg::TIME_W-1:0]         rsp_pred_time_us,
   output logic                               rsp_valid_res,
   output logic                               rsp_last,
   input  wire logic                          csr_we,
   input  wire logic [spp_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [spp_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int HIDX_W = $clog2(HISTORY_DEPTH);
   localparam int EMIT_W = $clog2(MAX_PREDICTED + 1);

   // One-hot sequencer. PREP forms the finite differences, DIVX and DIVY
   // normalize the two velocity components, MUL runs the speed and horizon
   // products, CHECK tests the first time against the limit, STEP and LAST build each predicted beat.
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_EXPIRE = 10'b0000000010,
      ST_PREP   = 10'b0000000100,
      ST_DIVX   = 10'b0000001000,
      ST_DIVY   = 10'b0000010000,
      ST_MUL    = 10'b0000100000,
      ST_CHECK  = 10'b0001000000,
      ST_STEP   = 10'b0010000000,
      ST_LAST   = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [spp_pkg::DUR_W-1:0]  dur_ff, dur_in;
   logic [spp_pkg::SIZE_W-1:0] wid_ff, wid_in;
   logic [spp_pkg::SIZE_W-1:0] hgt_ff, hgt_in;
   logic [spp_pkg::INT_W-1:0]  int_ff, int_in;
   logic [spp_pkg::GAP_W-1:0]  gap_ff, gap_in;
   logic [spp_pkg::LIFE_W-1:0] life_ff, life_in;

   // History, newest point in slot zero.
   logic signed [spp_pkg::POS_W-1:0] hist_x_ff [HISTORY_DEPTH];
   logic signed [spp_pkg::POS_W-1:0] hist_x_in [HISTORY_DEPTH];
   logic signed [spp_pkg::POS_W-1:0] hist_y_ff [HISTORY_DEPTH];
   logic signed [spp_pkg::POS_W-1:0] hist_y_in [HISTORY_DEPTH];
   logic [spp_pkg::TIME_W-1:0]       hist_t_ff [HISTORY_DEPTH];
   logic [spp_pkg::TIME_W-1:0]       hist_t_in [HISTORY_DEPTH];
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;

   // Working registers of a predict.
   logic [spp_pkg::TIME_W-1:0] now_ff, now_in;
   logic signed [35:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [35:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [35:0] jx_ff, jx_in, jy_ff, jy_in;
   logic signed [35:0] locx_ff, locx_in, locy_ff, locy_in;
   logic [24:0]        nx_ff, nx_in, ny_ff, ny_in;
   logic [48:0]        acc_ff, acc_in;
   logic [49:0]        s_ff, s_in;
   logic               big_ff, big_in;
   logic [63:0]        mul_ff, mul_in;
   logic [2:0]         ph_ff, ph_in;
   logic [49:0]        t_ff, t_in;
   logic [49:0]        limit_ff, limit_in;
   logic [EMIT_W-1:0]  emit_ff, emit_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [spp_pkg::POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [spp_pkg::TIME_W-1:0] rsp_t_ff, rsp_t_in;
   logic                       rsp_vr_ff, rsp_vr_in, rsp_last_ff, rsp_last_in;

   // Shared divider and multiplier.
   spp_pkg::div_ctl_type  div_ctl;
   spp_pkg::div_stat_type div_stat;
   logic [spp_pkg::DVD_W-1:0]  div_dvd, div_q;
   logic [spp_pkg::SIZE_W-1:0] div_dvs;
   logic [31:0] mul_a, mul_b;
   logic [24:0] q_sat;

   // Finite differences over the usable points, padded with zeros.
   logic signed [spp_pkg::POS_W-1:0] px [4];
   logic signed [spp_pkg::POS_W-1:0] py [4];
   logic [spp_pkg::TIME_W-1:0]       pt [4];
   logic signed [24:0] v0x, v1x, v2x, v0y, v1y, v2y;
   logic signed [25:0] a0x, a1x, a0y, a1y;
   logic signed [26:0] jdx, jdy;
   logic [3:0]         gap_ok;
   logic [2:0]         n_pts;
   logic               run;
   logic [24:0]        abs_vx, abs_vy;
   logic [HIDX_W-1:0]  old_idx;
   logic [CNT_W-1:0]   cnt_m1;
   logic               expired;
   logic signed [35:0] step_vx, step_vy, step_lx, step_ly;

   genvar gi;
   generate
      for (gi = 0; gi < 4; gi++) begin : g_pad
         if (gi < HISTORY_DEPTH) begin : g_have
            assign px[gi] = hist_x_ff[gi];
            assign py[gi] = hist_y_ff[gi];
            assign pt[gi] = hist_t_ff[gi];
         end else begin : g_none
            assign px[gi] = '0;
            assign py[gi] = '0;
            assign pt[gi] = '0;
         end
      end
   endgenerate

   always_comb begin
      v0x = 25'(px[0]) - 25'(px[1]);
      v1x = 25'(px[1]) - 25'(px[2]);
      v2x = 25'(px[2]) - 25'(px[3]);
      v0y = 25'(py[0]) - 25'(py[1]);
      v1y = 25'(py[1]) - 25'(py[2]);
      v2y = 25'(py[2]) - 25'(py[3]);
      a0x = 26'(v0x) - 26'(v1x);
      a1x = 26'(v1x) - 26'(v2x);
      a0y = 26'(v0y) - 26'(v1y);
      a1y = 26'(v1y) - 26'(v2y);
      jdx = 27'(a0x) - 27'(a1x);
      jdy = 27'(a0y) - 27'(a1y);
      abs_vx = v0x[24] ? 25'(-v0x) : 25'(v0x);
      abs_vy = vy_ff[35] ? 25'(-vy_ff) : 25'(vy_ff);
   end

   // A gap between neighbors counts as broken only when it is positive and
   // above the limit; points out of time order never break the run.
   always_comb begin
      logic signed [48:0] gd;
      gap_ok = '0;
      for (int i = 0; i < 3; i++) begin
         gd = 49'(pt[i]) - 49'(pt[i + 1]);
         gap_ok[i] = gd <= $signed({29'b0, gap_ff});
      end
      n_pts = (cnt_ff != '0) ? 3'd1 : 3'd0;
      run = 1'b1;
      for (int i = 1; i < 4; i++) begin
         run = run & (i < HISTORY_DEPTH) & (32'(cnt_ff) > i) & gap_ok[i - 1];
         if (run) begin
            n_pts = 3'(i + 1);
         end
      end
   end

   // Advance time looks at the oldest stored point.
   assign cnt_m1  = cnt_ff - 1'b1;
   assign old_idx = cnt_m1[HIDX_W-1:0];
   assign expired = (cnt_ff != '0) &&
                    ((49'(hist_t_ff[old_idx]) + 49'(life_ff)) <= {1'b0, now_ff});

   assign div_dvd = state_ff == ST_PREP ? {abs_vx, 16'b0} : {abs_vy, 16'b0};
   assign div_dvs = state_ff == ST_PREP ? wid_ff : hgt_ff;
   assign q_sat   = (div_q > 41'(spp_pkg::NORM_MAX)) ? spp_pkg::NORM_MAX : div_q[24:0];

   always_comb begin
      step_vx = vx_ff + ax_ff;
      step_vy = vy_ff + ay_ff;
      step_lx = locx_ff + step_vx;
      step_ly = locy_ff + step_vy;
   end

   always_comb begin
      state_in = state_ff;
      dur_in = dur_ff;  wid_in = wid_ff;  hgt_in = hgt_ff;
      int_in = int_ff;  gap_in = gap_ff;  life_in = life_ff;
      hist_x_in = hist_x_ff;  hist_y_in = hist_y_ff;  hist_t_in = hist_t_ff;
      cnt_in = cnt_ff;  now_in = now_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  ax_in = ax_ff;  ay_in = ay_ff;
      jx_in = jx_ff;  jy_in = jy_ff;  locx_in = locx_ff;  locy_in = locy_ff;
      nx_in = nx_ff;  ny_in = ny_ff;  acc_in = acc_ff;  s_in = s_ff;
      big_in = big_ff;  mul_in = mul_ff;  ph_in = ph_ff;
      t_in = t_ff;  limit_in = limit_ff;  emit_in = emit_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_x_in = rsp_x_ff;  rsp_y_in = rsp_y_ff;
      rsp_t_in = rsp_t_ff;  rsp_vr_in = rsp_vr_ff;  rsp_last_in = rsp_last_ff;
      div_ctl.start = 1'b0;
      mul_a = '0;
      mul_b = '0;

      if (csr_we) begin
         unique case (spp_pkg::csr_index_type'(csr_index))
            spp_pkg::CSR_DURATION: dur_in  = csr_wdata[spp_pkg::DUR_W-1:0];
            spp_pkg::CSR_WIDTH:    wid_in  = csr_wdata[spp_pkg::SIZE_W-1:0];
            spp_pkg::CSR_HEIGHT:   hgt_in  = csr_wdata[spp_pkg::SIZE_W-1:0];
            spp_pkg::CSR_INTERVAL: int_in  = csr_wdata[spp_pkg::INT_W-1:0];
            spp_pkg::CSR_MAX_GAP:  gap_in  = csr_wdata[spp_pkg::GAP_W-1:0];
            spp_pkg::CSR_LIFE:     life_in = csr_wdata[spp_pkg::LIFE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_time_us;
               unique case (spp_pkg::command_type'(req_command))
                  spp_pkg::CMD_ADD: begin
                     for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                        hist_x_in[i] = hist_x_ff[i - 1];
                        hist_y_in[i] = hist_y_ff[i - 1];
                        hist_t_in[i] = hist_t_ff[i - 1];
                     end
                     hist_x_in[0] = req_x_pos;
                     hist_y_in[0] = req_y_pos;
                     hist_t_in[0] = req_time_us;
                     if (32'(cnt_ff) < HISTORY_DEPTH) begin
                        cnt_in = cnt_ff + 1'b1;
                     end
                  end
                  spp_pkg::CMD_PREDICT: state_in = ST_PREP;
                  spp_pkg::CMD_CLEAR:   cnt_in = '0;
                  spp_pkg::CMD_ADVANCE: begin
                     if (life_ff != '0) begin
                        state_in = ST_EXPIRE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EXPIRE: begin
            if (expired) begin
               cnt_in = cnt_m1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP: begin
            emit_in = '0;
            if (cnt_ff == '0 || dur_ff == '0 || n_pts < 3'd2) begin
               rsp_x_in = '0;  rsp_y_in = '0;  rsp_t_in = '0;
               rsp_vr_in = 1'b0;  rsp_last_in = 1'b1;  rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end else begin
               vx_in = 36'(v0x);
               vy_in = 36'(v0y);
               ax_in = (n_pts >= 3'd3) ? 36'(a0x) : '0;
               ay_in = (n_pts >= 3'd3) ? 36'(a0y) : '0;
               jx_in = (n_pts >= 3'd4) ? 36'(jdx) : '0;
               jy_in = (n_pts >= 3'd4) ? 36'(jdy) : '0;
               locx_in = 36'(px[0]);
               locy_in = 36'(py[0]);
               t_in = 50'(hist_t_ff[0]) + 50'(int_ff);
               div_ctl.start = 1'b1;
               state_in = ST_DIVX;
            end
         end
         ST_DIVX: begin
            if (div_stat.done) begin
               nx_in = q_sat;
               div_ctl.start = 1'b1;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_stat.done) begin
               ny_in = q_sat;
               ph_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ph_in = ph_ff + 1'b1;
            case (ph_ff)
               3'd0: begin
                  mul_a = 32'(nx_ff);
                  mul_b = 32'(nx_ff);
               end
               3'd1: begin
                  acc_in = mul_ff[48:0];
                  mul_a = 32'(ny_ff);
                  mul_b = 32'(ny_ff);
               end
               3'd2: s_in = 50'(acc_ff) + 50'(mul_ff[48:0]);
               3'd3: begin
                  big_in = s_ff >= spp_pkg::SPEED_THRESH;
                  mul_a = s_ff[31:0];
                  mul_b = spp_pkg::SPEED_SCALE;
               end
               3'd4: begin
                  mul_a = 32'(dur_ff);
                  mul_b = mul_ff[47:16];
               end
               default: begin
                  limit_in = 50'(now_ff) + (big_ff ? 50'(dur_ff) : 50'(mul_ff[51:32]));
                  state_in = ST_CHECK;
               end
            endcase
            mul_in = 64'(mul_a) * 64'(mul_b);
         end
         ST_CHECK: begin
            if (t_ff < limit_ff) begin
               state_in = ST_STEP;
            end else begin
               rsp_x_in = '0;  rsp_y_in = '0;  rsp_t_in = '0;
               rsp_vr_in = 1'b0;  rsp_last_in = 1'b1;  rsp_valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_STEP: begin
            vx_in = step_vx;
            vy_in = step_vy;
            ax_in = ax_ff + jx_ff;
            ay_in = ay_ff + jy_ff;
            locx_in = step_lx;
            locy_in = step_ly;
            rsp_x_in = spp_pkg::sat24(step_lx);
            rsp_y_in = spp_pkg::sat24(step_ly);
            rsp_t_in = t_ff[spp_pkg::TIME_W-1:0];
            rsp_vr_in = 1'b1;
            t_in = t_ff + 50'(int_ff);
            emit_in = emit_ff + 1'b1;
            state_in = ST_LAST;
         end
         ST_LAST: begin
            // The next predicted time is already in t_ff here.
            rsp_last_in = (emit_ff == EMIT_W'(MAX_PREDICTED)) || !(t_ff < limit_ff);
            rsp_valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in = rsp_last_ff ? ST_IDLE : ST_STEP;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dur_ff  <= spp_pkg::DUR_RST;
         wid_ff  <= spp_pkg::WID_RST;
         hgt_ff  <= spp_pkg::HGT_RST;
         int_ff  <= spp_pkg::INT_RST;
         gap_ff  <= spp_pkg::GAP_RST;
         life_ff <= spp_pkg::LIFE_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dur_ff  <= dur_in;
         wid_ff  <= wid_in;
         hgt_ff  <= hgt_in;
         int_ff  <= int_in;
         gap_ff  <= gap_in;
         life_ff <= life_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_x_ff <= hist_x_in;
      hist_y_ff <= hist_y_in;
      hist_t_ff <= hist_t_in;
      now_ff <= now_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;  ax_ff <= ax_in;  ay_ff <= ay_in;
      jx_ff <= jx_in;  jy_ff <= jy_in;  locx_ff <= locx_in;  locy_ff <= locy_in;
      nx_ff <= nx_in;  ny_ff <= ny_in;  acc_ff <= acc_in;  s_ff <= s_in;
      big_ff <= big_in;  mul_ff <= mul_in;  ph_ff <= ph_in;
      t_ff <= t_in;  limit_ff <= limit_in;  emit_ff <= emit_in;
      rsp_x_ff <= rsp_x_in;  rsp_y_ff <= rsp_y_in;  rsp_t_ff <= rsp_t_in;
      rsp_vr_ff <= rsp_vr_in;  rsp_last_ff <= rsp_last_in;
   end

   spp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pred_x       = rsp_x_ff;
   assign rsp_pred_y       = rsp_y_ff;
   assign rsp_pred_time_us = rsp_t_ff;
   assign rsp_valid_res    = rsp_vr_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/spp_checker.sv */
`default_nettype none
`include "stroke_point_predictor_top_defines.svh"
module spp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [spp_pkg::POS_W-1:0]     rsp_pred_x,
   input wire logic [spp_pkg::POS_W-1:0]     rsp_pred_y,
   input wire logic [spp_pkg::TIME_W-1:0]    rsp_pred_time_us,
   input wire logic                          rsp_valid_res,
   input wire logic                          rsp_last
);

   `SPP_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "beat pending after reset")
   `SPP_ASSERT(a_busy_while_beat, !(req_ready && rsp_valid), "ready while a beat waits")
   `SPP_ASSERT(a_invalid_is_last, (rsp_valid && !rsp_valid_res) |-> rsp_last, "invalid beat not last")
   `SPP_ASSERT(a_invalid_zero, (rsp_valid && !rsp_valid_res) |-> (rsp_pred_x == '0 && rsp_pred_y == '0 && rsp_pred_time_us == '0), "invalid beat not zero")
   `SPP_ASSERT(a_beat_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pred_x) && $stable(rsp_last)), "stalled beat changed")

endmodule

bind stroke_point_predictor_top spp_checker u_spp_checker (.*);
`default_nettype wire

/* dv/stroke_point_predictor_checker.sv */
`default_nettype none
module stroke_point_predictor_checker
   import spp_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [1:0]               req_command,
   input  wire logic signed [POS_W-1:0]  req_x_pos,
   input  wire logic signed [POS_W-1:0]  req_y_pos,
   input  wire logic [TIME_W-1:0]        req_time_us,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic signed [POS_W-1:0]  rsp_pred_x,
   input  wire logic signed [POS_W-1:0]  rsp_pred_y,
   input  wire logic [TIME_W-1:0]        rsp_pred_time_us,
   input  wire logic                     rsp_valid_res,
   input  wire logic                     rsp_last,
   input  wire logic                     csr_we,
   input  wire logic [IDX_W-1:0]         csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata,
   output int                            pending,
   output int                            failures,
   output int                            beats_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [TIME_W-1:0]       stamp;
      logic                    present;
      logic                    last;
   } point_beat_t;

   point_beat_t expected_points[$];

   longint unsigned duration, width, height, interval, max_gap, life;
   longint          hist_x[HISTORY_DEPTH], hist_y[HISTORY_DEPTH];
   longint unsigned hist_stamp[HISTORY_DEPTH];
   int              hist_count;

   task automatic report(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      failures++;
   endtask

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[POS_W-1:0];
   endfunction

   // Velocity component over the screen size, as a Q16 magnitude.
   function automatic longint screen_speed(input longint v, input longint unsigned size);
      longint s;
      longint r;
      s = (size == 0) ? 1 : longint'(size);
      r = (v * 65536) / s;
      if (r < 0) r = -r;
      if (r > (64'sd1 << 24)) r = 64'sd1 << 24;
      return r;
   endfunction

   task automatic push_no_prediction();
      point_beat_t b;
      b = '{'0, '0, '0, 1'b0, 1'b1};
      expected_points.insert(expected_points.size(), b);
   endtask

   task automatic drop_oldest_points(input int n);
      if (n > hist_count) n = hist_count;
      for (int i = 0; i + n < hist_count; i++) begin
         hist_x[i] = hist_x[i + n];
         hist_y[i] = hist_y[i + n];
         hist_stamp[i] = hist_stamp[i + n];
      end
      hist_count -= n;
   endtask

   task automatic extrapolate_stroke(input longint unsigned now);
      longint px[4], py[4], vx[3], vy[3], ax[2], ay[2];
      longint jx, jy, locx, locy, spread, nx, ny;
      longint unsigned newest, s, k, horizon, limit, t;
      int n, emitted;
      point_beat_t b;
      n = 0;
      emitted = 0;
      jx = 0;
      jy = 0;
      if (hist_count == 0 || duration == 0) begin
         push_no_prediction();
         return;
      end
      newest = hist_stamp[hist_count - 1];
      for (int i = hist_count; i > 0 && n < 4; i--) begin
         spread = longint'(newest) - longint'(hist_stamp[i - 1]);
         if (spread > longint'(max_gap)) break;
         newest = hist_stamp[i - 1];
         px[n] = hist_x[i - 1];
         py[n] = hist_y[i - 1];
         n++;
      end
      if (n < 2) begin
         push_no_prediction();
         return;
      end
      for (int i = 0; i + 1 < n; i++) begin
         vx[i] = px[i] - px[i + 1];
         vy[i] = py[i] - py[i + 1];
      end
      ax[0] = 0;
      ay[0] = 0;
      for (int i = 0; i + 2 < n; i++) begin
         ax[i] = vx[i] - vx[i + 1];
         ay[i] = vy[i] - vy[i + 1];
      end
      if (n > 3) begin
         jx = ax[0] - ax[1];
         jy = ay[0] - ay[1];
      end
      nx = screen_speed(vx[0], width);
      ny = screen_speed(vy[0], height);
      s = longint'(nx * nx) + longint'(ny * ny);
      // Fast strokes use the whole horizon; slow ones shrink it.
      if (s >= (64'd1 << 48) / 100000 + 1) begin
         horizon = duration;
      end else begin
         k = s * 100000;
         if (k >= (64'd1 << 48)) horizon = duration;
         else horizon = (duration * (k >> 16)) >> 32;
      end
      if (horizon > duration) horizon = duration;
      limit = now + horizon;
      locx = px[0];
      locy = py[0];
      t = hist_stamp[hist_count - 1] + interval;
      while (t < limit && emitted < MAX_PREDICTED) begin
         vx[0] += ax[0];
         vy[0] += ay[0];
         ax[0] += jx;
         ay[0] += jy;
         locx += vx[0];
         locy += vy[0];
         b = '{clamp_pos(locx), clamp_pos(locy), t[TIME_W-1:0], 1'b1, 1'b0};
         expected_points.insert(expected_points.size(), b);
         emitted++;
         t += interval;
      end
      if (emitted == 0) push_no_prediction();
      else expected_points[expected_points.size() - 1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      point_beat_t want;
      int d;
      if (reset) begin
         expected_points.delete();
         duration = DUR_RST;
         width = WID_RST;
         height = HGT_RST;
         interval = INT_RST;
         max_gap = GAP_RST;
         life = LIFE_RST;
         hist_count = 0;
         failures = 0;
         beats_seen = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DURATION: duration = csr_wdata[DUR_W-1:0];
               CSR_WIDTH:    width = csr_wdata[SIZE_W-1:0];
               CSR_HEIGHT:   height = csr_wdata[SIZE_W-1:0];
               CSR_INTERVAL: interval = csr_wdata[INT_W-1:0];
               CSR_MAX_GAP:  max_gap = csr_wdata[GAP_W-1:0];
               CSR_LIFE:     life = csr_wdata[LIFE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (expected_points.size() == 0) begin
               report("result beat with no prediction outstanding");
            end else begin
               want = expected_points.pop_front();
               if (rsp_pred_x !== want.x)
                  report($sformatf("pred_x %h, want %h", rsp_pred_x, want.x));
               if (rsp_pred_y !== want.y)
                  report($sformatf("pred_y %h, want %h", rsp_pred_y, want.y));
               if (rsp_pred_time_us !== want.stamp)
                  report($sformatf("pred_time_us %h, want %h", rsp_pred_time_us,
                                   want.stamp));
               if (rsp_valid_res !== want.present)
                  report($sformatf("valid_res %b, want %b", rsp_valid_res, want.present));
               if (rsp_last !== want.last)
                  report($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         if (req_valid && req_ready) begin
            case (command_type'(req_command))
               CMD_ADD: begin
                  if (hist_count >= HISTORY_DEPTH) drop_oldest_points(1);
                  hist_x[hist_count] = req_x_pos;
                  hist_y[hist_count] = req_y_pos;
                  hist_stamp[hist_count] = req_time_us;
                  hist_count++;
               end
               CMD_PREDICT: extrapolate_stroke(req_time_us);
               CMD_CLEAR: hist_count = 0;
               CMD_ADVANCE: begin
                  if (life != 0) begin
                     d = 0;
                     while (d < hist_count && hist_stamp[d] + life <= req_time_us) d++;
                     drop_oldest_points(d);
                  end
               end
            endcase
         end
      end
      pending = expected_points.size();
   end
endmodule
`default_nettype wire

/* dv/stroke_point_predictor_top_tb.sv */
`default_nettype none
module stroke_point_predictor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spp_pkg::*;

   // Register index that decodes to nothing; writes to it must be ignored.
   localparam logic [IDX_W-1:0] CSR_SPARE = 3'd6;
   localparam int NUM_PHASES = 6;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [1:0]              req_command;
   logic signed [POS_W-1:0] req_x_pos;
   logic signed [POS_W-1:0] req_y_pos;
   logic [TIME_W-1:0]       req_time_us;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [POS_W-1:0] rsp_pred_x;
   logic signed [POS_W-1:0] rsp_pred_y;
   logic [TIME_W-1:0]       rsp_pred_time_us;
   logic                    rsp_valid_res;
   logic                    rsp_last;
   logic                    csr_we;
   logic [IDX_W-1:0]        csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   int pending, failures, beats_seen;
   int items_sent, burst_left, stall_left, stall_mode;
   longint pen_x, pen_y, pen_vx, pen_vy;
   logic [TIME_W-1:0] pen_clock;

   // Register settings per random phase: extremes, zero sizes and a zero
   // interval, plus ordinary pen-tablet values.
   longint unsigned phase_dur[NUM_PHASES] = '{100000, 1000000, 20000, 50000, 1048575, 1};
   longint unsigned phase_wid[NUM_PHASES] = '{1920, 1, 16384, 0, 800, 640};
   longint unsigned phase_hgt[NUM_PHASES] = '{1080, 1, 16384, 0, 600, 480};
   longint unsigned phase_int[NUM_PHASES] = '{5000, 1, 100000, 0, 3000, 2000};
   longint unsigned phase_gap[NUM_PHASES] = '{10000, 1000000, 0, 8000, 20000, 5000};
   longint unsigned phase_life[NUM_PHASES] = '{0, 100000000, 5000, 0, 27'h7FFFFFF, 15000};

   stroke_point_predictor_top DUT (.*);

   stroke_point_predictor_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver cycles through stretches of always ready, random stalls
   // and long stalls, so back-pressure can land on any beat of a prediction.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = 1'($urandom_range(0, 1));
         default: rsp_ready = ($urandom_range(0, 5) == 0);
      endcase
   end

   // Called at a falling edge; returns at the falling edge after the beat.
   // Between bursts valid either stays high or drops for a random gap.
   task automatic send_beat(input command_type cmd, input longint x, input longint y,
                            input logic [TIME_W-1:0] stamp);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_command = cmd;
      req_x_pos = x[POS_W-1:0];
      req_y_pos = y[POS_W-1:0];
      req_time_us = stamp;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // Lets the block finish, including a trailing advance, before registers move.
   task automatic drain();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input longint unsigned value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Mostly a plausible stroke with random content; now and then a point
   // anywhere in the field ranges, a step back in time or a long pause.
   task automatic random_beat();
      int pick;
      longint unsigned step;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 19) == 0) begin
            pen_x = longint'($signed(24'($urandom)));
            pen_y = longint'($signed(24'($urandom)));
            pen_clock = {16'($urandom), 32'($urandom)};
         end else begin
            pen_vx += $signed($urandom_range(0, 800)) - 400;
            pen_vy += $signed($urandom_range(0, 800)) - 400;
            pen_x += pen_vx;
            pen_y += pen_vy;
            if (pen_x > 8388607 || pen_x < -8388608) pen_x = 0;
            if (pen_y > 8388607 || pen_y < -8388608) pen_y = 0;
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
                                               : $urandom_range(0, 6000);
            if ($urandom_range(0, 24) == 0) pen_clock -= $urandom_range(1, 3000);
            else pen_clock = TIME_W'(pen_clock + step);
         end
         send_beat(CMD_ADD, pen_x, pen_y, pen_clock);
      end else if (pick < 82) begin
         send_beat(CMD_PREDICT, longint'($signed(24'($urandom))), 0,
                   pen_clock + $urandom_range(0, 4000));
      end else if (pick < 87) begin
         send_beat(CMD_CLEAR, 0, 0, {16'($urandom), 32'($urandom)});
      end else begin
         send_beat(CMD_ADVANCE, 0, 0, pen_clock + $urandom_range(0, 30000));
      end
   endtask

   initial begin
      int fails;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_ADD;
      req_x_pos = '0;
      req_y_pos = '0;
      req_time_us = '0;
      csr_we = 1'b0;
      csr_index = CSR_DURATION;
      csr_wdata = '0;
      items_sent = 0;
      burst_left = 0;
      pen_x = 0;
      pen_y = 0;
      pen_vx = 0;
      pen_vy = 0;
      pen_clock = 48'd100000;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed part under the reset settings, with a horizon and a life.
      write_csr(CSR_DURATION, 100000);
      write_csr(CSR_LIFE, 30000);
      send_beat(CMD_PREDICT, 0, 0, 0);                  // empty history
      send_beat(CMD_ADD, 8388607, -8388608, 1000);
      send_beat(CMD_PREDICT, 0, 0, 1000);               // a single point
      send_beat(CMD_ADD, -8388608, 8388607, 2000);
      send_beat(CMD_PREDICT, 0, 0, 2000);               // saturated extrapolation
      send_beat(CMD_ADD, 1000, 1000, 3000);
      send_beat(CMD_ADD, 2000, 1500, 4000);
      send_beat(CMD_PREDICT, 0, 0, 4000);               // full history, jerk in use
      send_beat(CMD_ADD, 2500, 1800, 5000);             // oldest point falls out
      send_beat(CMD_ADD, 2600, 2000, 4500);             // out of time order
      send_beat(CMD_PREDICT, 0, 0, 5000);
      send_beat(CMD_ADD, 2700, 2100, 30000);            // gap above the limit
      send_beat(CMD_PREDICT, 0, 0, 30000);
      send_beat(CMD_ADVANCE, 0, 0, 45000);              // older points expire
      send_beat(CMD_PREDICT, 0, 0, 45000);
      send_beat(CMD_CLEAR, 0, 0, 0);
      send_beat(CMD_PREDICT, 0, 0, 45000);
      send_beat(CMD_ADD, 0, 0, 48'hFFFF_FFFF_FF00);
      send_beat(CMD_ADD, 256, -256, 48'hFFFF_FFFF_FFFF);
      send_beat(CMD_PREDICT, 0, 0, 48'hFFFF_FFFF_FFFF); // predicted times wrap
      send_beat(CMD_ADVANCE, 0, 0, 48'hFFFF_FFFF_FFFF);
      send_beat(CMD_PREDICT, 0, 0, 0);                  // no point before the limit
      drain();
      write_csr(CSR_DURATION, 0);
      send_beat(CMD_PREDICT, 0, 0, 48'hFFFF_FFFF_FFFF); // prediction switched off
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_DURATION, phase_dur[p]);
         write_csr(CSR_WIDTH, phase_wid[p]);
         write_csr(CSR_HEIGHT, phase_hgt[p]);
         write_csr(CSR_INTERVAL, phase_int[p]);
         write_csr(CSR_MAX_GAP, phase_gap[p]);
         write_csr(CSR_LIFE, phase_life[p]);
         if (p == 3) begin
            write_csr(CSR_SPARE, 27'h7FFFFFF);
            write_csr(CSR_SPARE + 3'd1, 27'h5555555);
         end
         for (int i = 0; i < 72; i++) begin
            random_beat();
            // Once per phase the sender holds off until every beat is back.
            if (i == 36) drain();
         end
         drain();
      end

      repeat (200) @(negedge clock);
      fails = failures;
      if (pending != 0) begin
         $display("%0d predicted beats never arrived", pending);
         fails++;
      end
      $display("Covered %0d requests and %0d result beats over %0d register settings,",
               items_sent, beats_seen, NUM_PHASES + 1);
      $display("with burst gaps on the request side and random result stalls.");
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
